/* rtl/mtg_pkg.sv */
// Package: types, constants, microcode program and tempering for the MT19937 generator.
`timescale 1ns / 1ps
`default_nettype none
package mtg_pkg;

  localparam int STATE_WORDS = 624;
  localparam int ADDR_W      = $clog2(STATE_WORDS);
  localparam int WORD_W      = 32;
  localparam int PC_W        = 4;

  localparam logic [ADDR_W-1:0] LAST_WORD    = ADDR_W'(STATE_WORDS - 1);
  localparam logic [ADDR_W-1:0] USED_UP      = ADDR_W'(STATE_WORDS);
  localparam logic [ADDR_W-1:0] NEVER_SEEDED = ADDR_W'(STATE_WORDS + 1);
  localparam logic [ADDR_W-1:0] MIX_OFFSET   = ADDR_W'(397);

  localparam logic [WORD_W-1:0] TWIST_XOR    = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd6069;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;

  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // Program step addresses
  localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] PC_DISPATCH  = 4'd1;
  localparam logic [PC_W-1:0] PC_CHECK     = 4'd2;
  localparam logic [PC_W-1:0] PC_SEED      = 4'd3;
  localparam logic [PC_W-1:0] PC_AFTER     = 4'd4;
  localparam logic [PC_W-1:0] PC_RB_START  = 4'd5;
  localparam logic [PC_W-1:0] PC_RB_FIRST  = 4'd6;
  localparam logic [PC_W-1:0] PC_RB_NEXT   = 4'd7;
  localparam logic [PC_W-1:0] PC_RB_MIX    = 4'd8;
  localparam logic [PC_W-1:0] PC_RB_WRITE  = 4'd9;
  localparam logic [PC_W-1:0] PC_RB_DONE   = 4'd10;
  localparam logic [PC_W-1:0] PC_DRAW_READ = 4'd11;
  localparam logic [PC_W-1:0] PC_DRAW_WAIT = 4'd12;
  localparam logic [PC_W-1:0] PC_DRAW_OUT  = 4'd13;

  typedef enum logic [2:0] {
    C_NEXT,        // fall through
    C_JUMP,        // always jump
    C_WAIT_IN,     // jump while no transaction is taken
    C_DRAW_READY,  // draw pending and table has unused words
    C_DRAW_USED,   // draw pending and table used up
    C_NOT_LAST,    // word counter not at last word
    C_SEED_ONLY,   // no draw pending
    C_OUT_BUSY     // output register full and stalled
  } cond_t;

  typedef enum logic [1:0] {
    A_ZERO,
    A_NEXT,
    A_MIX,
    A_INDEX
  } addr_sel_t;

  typedef struct packed {
    logic            take_in;
    logic            rd_en;
    addr_sel_t       rd_sel;
    logic            wr_en;
    logic            wr_twist;
    logic            seed_step;
    logic            rb_init;
    logic            ld_first;
    logic            ld_nxt;
    logic            rb_step;
    logic            idx_zero;
    logic            out_load;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c        = '0;
    c.rd_sel = A_ZERO;
    c.cond   = C_NEXT;
    c.target = PC_IDLE;
    case (pc)
      PC_IDLE: begin
        c.take_in = 1'b1;
        c.cond    = C_WAIT_IN;
        c.target  = PC_IDLE;
      end
      PC_DISPATCH: begin
        c.cond   = C_DRAW_READY;
        c.target = PC_DRAW_READ;
      end
      PC_CHECK: begin
        c.cond   = C_DRAW_USED;
        c.target = PC_RB_START;
      end
      PC_SEED: begin
        c.wr_en     = 1'b1;
        c.seed_step = 1'b1;
        c.cond      = C_NOT_LAST;
        c.target    = PC_SEED;
      end
      PC_AFTER: begin
        c.cond   = C_SEED_ONLY;
        c.target = PC_IDLE;
      end
      PC_RB_START: begin
        c.rd_en   = 1'b1;
        c.rd_sel  = A_ZERO;
        c.rb_init = 1'b1;
      end
      PC_RB_FIRST: begin
        c.ld_first = 1'b1;
      end
      PC_RB_NEXT: begin
        c.rd_en  = 1'b1;
        c.rd_sel = A_NEXT;
      end
      PC_RB_MIX: begin
        c.ld_nxt = 1'b1;
        c.rd_en  = 1'b1;
        c.rd_sel = A_MIX;
      end
      PC_RB_WRITE: begin
        c.wr_en    = 1'b1;
        c.wr_twist = 1'b1;
        c.rb_step  = 1'b1;
        c.cond     = C_NOT_LAST;
        c.target   = PC_RB_NEXT;
      end
      PC_RB_DONE: begin
        c.idx_zero = 1'b1;
      end
      PC_DRAW_READ: begin
        c.rd_en  = 1'b1;
        c.rd_sel = A_INDEX;
      end
      PC_DRAW_WAIT: begin
        c.cond   = C_OUT_BUSY;
        c.target = PC_DRAW_WAIT;
      end
      PC_DRAW_OUT: begin
        c.out_load = 1'b1;
        c.cond     = C_JUMP;
        c.target   = PC_IDLE;
      end
      default: begin
        c.cond   = C_JUMP;
        c.target = PC_IDLE;
      end
    endcase
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y);
    logic [WORD_W-1:0] y1;
    logic [WORD_W-1:0] y2;
    logic [WORD_W-1:0] y3;
    y1 = y ^ (y >> 11);
    y2 = y1 ^ ((y1 << 7) & TEMPER_B);
    y3 = y2 ^ ((y2 << 15) & TEMPER_C);
    return y3 ^ (y3 >> 18);
  endfunction

endpackage
`default_nettype wire

/* rtl/mtg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/mersenne_twister_generator_top.sv */
// Top level of the MT19937 generator: microcode sequencer, datapath and state table.
`timescale 1ns / 1ps
`default_nettype none
// MT19937 word generator with a 624-word state table in RAM. A transaction with
// command 0 seeds the table (word 0 = seed_value, each next word = previous *
// 6069 mod 2^32) and returns nothing; command 1 returns one tempered word. A
// draw made before any seed first seeds with 4357. The twist rebuilds the table
// at the first draw after a seed and whenever all 624 words have been used;
// the last rebuilt word takes its low 31 bits from the value word 0 held
// before the rebuild. A small microcode program in a ROM steps a plain
// datapath around one RAM port pair (one write, one registered read). For
// each rebuilt word the program reads the next word, then reads the word 397
// ahead, then writes the new word, since the single read port serves two
// reads per word. in_stall is low only while the sequencer waits for a
// transaction; a finished word sits in the output register, so the next
// transaction is taken while it waits to be collected. No clearing pass
// follows reset.
module mersenne_twister_generator_top
  import mtg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [31:0] seed_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] random_word
);

  // Sequencer
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ctrl_t           ctrl;
  logic            cond_true;
  logic            in_take;
  logic            out_busy;

  // Datapath registers
  logic              draw_pend;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] k;
  logic [ADDR_W-1:0] m;
  logic [WORD_W-1:0] v;
  logic [WORD_W-1:0] cur;
  logic [WORD_W-1:0] nxt;
  logic [WORD_W-1:0] first_old;

  // RAM wiring
  logic [ADDR_W-1:0] raddr;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] y;
  logic [WORD_W-1:0] mixed;
  logic [ADDR_W-1:0] k_inc;
  logic [ADDR_W-1:0] m_inc;

  assign ctrl     = ucode(pc);
  assign in_stall = !ctrl.take_in;
  assign in_take  = in_valid && !in_stall;
  assign out_busy = out_valid && out_stall;

  // Pick the jump condition named by the control word
  always_comb begin
    case (ctrl.cond)
      C_NEXT:       cond_true = 1'b0;
      C_JUMP:       cond_true = 1'b1;
      C_WAIT_IN:    cond_true = !in_take;
      C_DRAW_READY: cond_true = draw_pend && (idx < USED_UP);
      C_DRAW_USED:  cond_true = draw_pend && (idx == USED_UP);
      C_NOT_LAST:   cond_true = (k != LAST_WORD);
      C_SEED_ONLY:  cond_true = !draw_pend;
      C_OUT_BUSY:   cond_true = out_busy;
      default:      cond_true = 1'b0;
    endcase
    pc_next = cond_true ? ctrl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Counters with wrap at the end of the table
  assign k_inc = (k == LAST_WORD) ? '0 : k + 1'b1;
  assign m_inc = (m == LAST_WORD) ? '0 : m + 1'b1;

  always_comb begin
    case (ctrl.rd_sel)
      A_ZERO:  raddr = '0;
      A_NEXT:  raddr = k_inc;
      A_MIX:   raddr = m;
      A_INDEX: raddr = idx;
      default: raddr = '0;
    endcase
  end

  // Twist of word k: upper bit of the current word, lower bits of the next
  assign y     = {cur[WORD_W-1], nxt[WORD_W-2:0]};
  assign mixed = rdata ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
  assign wdata = ctrl.wr_twist ? mixed : v;

  mtg_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STATE_WORDS)
  ) u_table (
    .clk  (clk),
    .we   (ctrl.wr_en),
    .waddr(k),
    .wdata(wdata),
    .re   (ctrl.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Read index: reset to never seeded
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= NEVER_SEEDED;
    end else if (ctrl.seed_step) begin
      idx <= USED_UP;
    end else if (ctrl.idx_zero) begin
      idx <= '0;
    end else if (ctrl.out_load) begin
      idx <= idx + 1'b1;
    end
  end

  // Control flag and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_pend <= 1'b0;
    end else if (in_take) begin
      draw_pend <= (command == CMD_DRAW);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      v <= (command == CMD_SEED) ? seed_value : DEFAULT_SEED;
      k <= '0;
    end else if (ctrl.seed_step) begin
      v <= 32'(v * SEED_MULT);
      k <= k + 1'b1;
    end else if (ctrl.rb_init) begin
      k <= '0;
    end else if (ctrl.rb_step) begin
      k <= k_inc;
    end
    if (ctrl.rb_init) begin
      m <= MIX_OFFSET;
    end else if (ctrl.rb_step) begin
      m <= m_inc;
    end
    if (ctrl.ld_first) begin
      cur       <= rdata;
      first_old <= rdata;
    end else if (ctrl.rb_step) begin
      cur <= nxt;
    end
    // Last word takes its low bits from the old word 0
    if (ctrl.ld_nxt) begin
      nxt <= (k == LAST_WORD) ? first_old : rdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      random_word <= temper(rdata);
    end
  end

  // Read index never leaves its legal range
  assert property (@(posedge clk) disable iff (rst) idx <= NEVER_SEEDED)
    else $error("read index out of range");

  // A new word never overwrites one still waiting at the output
  assert property (@(posedge clk) disable iff (rst) ctrl.out_load |-> !out_busy)
    else $error("output overwritten while stalled");

  // The mix pointer stays 397 words ahead of the twist pointer
  assert property (@(posedge clk) disable iff (rst)
    ctrl.rb_step |-> ((k < ADDR_W'(STATE_WORDS - 397)) ? (m == k + MIX_OFFSET)
                      : (m == k - ADDR_W'(STATE_WORDS - 397))))
    else $error("mix pointer out of step");

  // A result appears only from the output step of the program
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pc) == PC_DRAW_OUT)
    else $error("result without a draw");

endmodule
`default_nettype wire

/* test/mersenne_twister_generator_top_tb.sv */
// Self-checking testbench for the MT19937 word generator: seed and draw traffic against a model.
`timescale 1ns / 1ps
module mersenne_twister_generator_top_tb;
  import mtg_pkg::*;

  // One input transaction as the driver presents it.
  typedef struct packed {
    logic        cmd;
    logic [31:0] seed;
  } mt_request_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic        command    = CMD_SEED;
  logic [31:0] seed_value = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [31:0] random_word;

  mersenne_twister_generator_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .seed_value  (seed_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_word (random_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state: our own copy of the state table and the read pointer.
  logic [31:0] mt_words [STATE_WORDS];
  logic [9:0]  word_ptr = NEVER_SEEDED;

  mt_request_t pending_requests [$];
  logic [31:0] expected_words [$];

  int mismatches = 0;
  int draws_seen = 0;
  int in_gap     = 0;
  int in_calm    = 0;
  int stall_left = 0;
  int out_calm   = 0;

  task automatic report(input string msg);
    $display("%0t ns  mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Fill the table from a seed: each word is the one before it times the multiplier.
  function automatic void load_seed(input logic [31:0] s);
    logic [31:0] v;
    v = s;
    mt_words[0] = v;
    for (int k = 1; k < STATE_WORDS; k++) begin
      v = v * SEED_MULT;
      mt_words[k] = v;
    end
    word_ptr = USED_UP;
  endfunction

  // Regenerate every word by the twist. Note the last word pairs with the
  // value word 0 had before this pass, not with the freshly written word 0.
  function automatic void twist_table();
    logic [31:0] first_old;
    logic [31:0] nxt;
    logic [31:0] y;
    logic [31:0] mixed;
    first_old = mt_words[0];
    for (int k = 0; k < STATE_WORDS; k++) begin
      nxt   = (k + 1 < STATE_WORDS) ? mt_words[k + 1] : first_old;
      y     = {mt_words[k][31], nxt[30:0]};
      mixed = mt_words[(k + int'(MIX_OFFSET)) % STATE_WORDS];
      mt_words[k] = mixed ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'h0);
    end
  endfunction

  function automatic logic [31:0] tempered(input logic [31:0] w);
    logic [31:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    return t ^ (t >> 18);
  endfunction

  // Advance the model by one accepted transaction; queue the word a draw returns.
  function automatic void advance_generator(input mt_request_t req);
    if (req.cmd == CMD_SEED) begin
      load_seed(req.seed);
    end else begin
      if (word_ptr >= USED_UP) begin
        if (word_ptr != USED_UP) load_seed(DEFAULT_SEED);
        twist_table();
        word_ptr = '0;
      end
      expected_words.push_back(tempered(mt_words[word_ptr]));
      word_ptr = word_ptr + 10'd1;
    end
  endfunction

  // Idle length: mostly none or short, a few long, with calm stretches of none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 19))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_request(input logic cmd, input logic [31:0] seed);
    pending_requests.push_back('{cmd: cmd, seed: seed});
  endtask

  task automatic add_draws(input int n);
    repeat (n) add_request(CMD_DRAW, $urandom);
  endtask

  // Driver: present queued transactions, hold them while stalled, and feed
  // every accepted one to the model at the edge that takes it.
  always @(posedge clk) begin : drive_in
    mt_request_t req;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) advance_generator('{cmd: command, seed: seed_value});
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          req = pending_requests.pop_front();
          command    <= req.cmd;
          seed_value <= req.seed;
          in_valid   <= 1'b1;
          in_gap = pick_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each collected word with the oldest prediction and
  // stall the output at random, independent of whether a word is waiting.
  always @(posedge clk) begin : watch_out
    logic [31:0] want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report($sformatf("random_word %08h arrived with no draw pending", random_word));
        end else begin
          want = expected_words.pop_front();
          if (random_word !== want)
            report($sformatf("draw %0d: random_word %08h, want %08h",
                             draws_seen, random_word, want));
        end
        draws_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(out_calm);
      end
    end
  end

  initial begin
    int total;
    int r;

    // Directed part. Draw first so the block has to fall back on its default seed.
    add_request(CMD_DRAW, 32'hFFFF_FFFF);
    add_request(CMD_DRAW, 32'h0000_0000);
    add_request(CMD_SEED, 32'h0000_0000);
    add_draws(2);
    add_request(CMD_SEED, 32'hFFFF_FFFF);
    add_draws(2);
    add_request(CMD_SEED, 32'h0000_0001);
    add_draws(1);
    add_request(CMD_SEED, 32'h8000_0000);
    add_draws(1);
    add_request(CMD_SEED, 32'h7FFF_FFFF);
    add_draws(1);
    add_request(CMD_SEED, DEFAULT_SEED);
    add_draws(2);
    // Back-to-back seeds: only the second should count.
    add_request(CMD_SEED, 32'h1234_5678);
    add_request(CMD_SEED, 32'hA5A5_5A5A);
    add_draws(3);

    // Random part. Mostly a seed followed by a run of draws; one long run
    // crosses the table end twice so the last-word wrap and a second rebuild
    // built on it both get checked. The rest is draws alone and bare seeds.
    total = 0;
    while (total < 700) begin
      if (total >= 40 && total < 80) begin
        add_request(CMD_SEED, pick_seed());
        add_draws(630);
        total += 631;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          add_request(CMD_SEED, pick_seed());
          r = $urandom_range(1, 12);
          add_draws(r);
          total += r + 1;
        end else if (r < 85) begin
          r = $urandom_range(1, 8);
          add_draws(r);
          total += r;
        end else begin
          add_request(CMD_SEED, pick_seed());
          total++;
        end
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Drain: wait until everything is taken and every word has come back,
    // then allow a trailing seed to finish its pass over the table.
    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);

    if (mismatches == 0) begin
      $display("** mersenne_twister_generator_top: PASSED **");
    end else begin
      $display("** mersenne_twister_generator_top: FAILED **");
    end
    $finish;
  end

  // Watchdog: several times the slowest plausible run.
  initial begin
    #20_000_000;
    $display("** mersenne_twister_generator_top: FAILED **");
    $finish;
  end

endmodule

/* mersenne_twister_generator_top.f */
rtl/mtg_pkg.sv
rtl/mtg_ram.sv
rtl/mersenne_twister_generator_top.sv
test/mersenne_twister_generator_top_tb.sv
